/* design/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// Shared constants, register indexes and request types of the cascaded
// height-field sampler.
// ----------------------------------------------------------------------------
package chs_pkg;

  // Map geometry; DIM must be a power of two of at least four.
  localparam int DIM          = 256;
  localparam int LOG2_DIM     = $clog2(DIM);
  localparam int NUM_CASCADES = 3;
  localparam int MAP_SIZE     = DIM * DIM;
  localparam int HALF_W       = LOG2_DIM - 1;
  localparam int BANK_AW      = 2 * HALF_W;
  localparam int BANK_DEPTH   = MAP_SIZE / 4;

  // Field widths.
  localparam int COORD_W  = 32;
  localparam int HEIGHT_W = 16;
  localparam int INDEX_W  = 16;
  localparam int PROD_W   = 57;
  localparam int BLEND_W  = 25;
  localparam int RESULT_W = 33;
  localparam int SUM_W    = 35;
  localparam int WAVE_P_W = 52;

  // Operation codes.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_WAVE_SCALE    = 3'd0;
  localparam logic [2:0] REG_TEXEL_SCALE_0 = 3'd1;
  localparam logic [2:0] REG_TEXEL_SCALE_1 = 3'd2;
  localparam logic [2:0] REG_TEXEL_SCALE_2 = 3'd3;
  localparam logic [2:0] REG_OUT_SCALE_0   = 3'd4;
  localparam logic [2:0] REG_OUT_SCALE_1   = 3'd5;
  localparam logic [2:0] REG_OUT_SCALE_2   = 3'd6;

  typedef logic [LOG2_DIM-1:0] texel_t;

  // One texel write request towards a map.
  typedef struct packed {
    logic                en;
    texel_t              row;
    texel_t              col;
    logic [HEIGHT_W-1:0] data;
  } map_write_t;

  // Lower-left texel of a bilinear footprint.
  typedef struct packed {
    texel_t x;
    texel_t z;
  } map_read_t;

endpackage

/* design/cascaded_heightfield_sampler.sv */
// ----------------------------------------------------------------------------
// cascaded_heightfield_sampler
// Three banked height maps with bilinear repeat-wrap sampling.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while not stalled, write or sample, and
// returns one height per sample; writes give no result.
// The rate is set by the four parity banks of each map, which serve all four
// footprint texels of every cascade together. Writes reach the maps
// at the same pipeline stage as sample reads, so requests see the maps in
// the order they were taken. The whole pipeline holds while a result waits
// under stall. Map entries are undefined until written.
module cascaded_heightfield_sampler
  import chs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic                       operation,
  input  logic signed [COORD_W-1:0]  world_x,
  input  logic signed [COORD_W-1:0]  world_z,
  input  logic [2:0]                 cascade_mask,
  input  logic [1:0]                 cascade_select,
  input  logic [INDEX_W-1:0]         entry_index,
  input  logic signed [HEIGHT_W-1:0] height_value,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [31:0]         height
);

  logic        en;
  logic [15:0] wave_scale;
  logic [23:0] texel_scale [NUM_CASCADES];
  logic [31:0] out_scale [NUM_CASCADES];

  logic vld_a, vld_b, vld_c, vld_d, vld_e, vld_f, vld_g, vld_h;
  logic                       op_a;
  logic signed [COORD_W-1:0]  wx_a;
  logic signed [COORD_W-1:0]  wz_a;
  logic [2:0]                 mask_a, mask_b, mask_c, mask_d, mask_e, mask_f;
  logic [1:0]                 sel_a;
  logic [INDEX_W-1:0]         idx_a;
  logic [HEIGHT_W-1:0]        hv_a;

  map_write_t                 wr_b;
  logic [1:0]                 sel_b;
  map_read_t                  rd_b [NUM_CASCADES];
  logic [15:0]                tx_b [NUM_CASCADES];
  logic [15:0]                tz_b [NUM_CASCADES];
  logic [15:0]                tx_c [NUM_CASCADES];
  logic [15:0]                tz_c [NUM_CASCADES];
  logic signed [RESULT_W-1:0] res_f [NUM_CASCADES];
  logic signed [SUM_W-1:0]    sum_g;
  logic signed [WAVE_P_W-1:0] prod_h;
  logic signed [WAVE_P_W-1:0] rounded;
  logic [31:0]                idx_ext;

  // The pipeline moves unless a finished result is held under stall.
  assign en           = !result_valid || !result_stall;
  assign sample_stall = !en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_scale <= 16'd256;
      for (int c = 0; c < NUM_CASCADES; c++) begin
        texel_scale[c] <= 24'd65536;
        out_scale[c]   <= 32'd16777216;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WAVE_SCALE:    wave_scale     <= cfg_data[15:0];
        REG_TEXEL_SCALE_0: texel_scale[0] <= cfg_data[23:0];
        REG_TEXEL_SCALE_1: texel_scale[1] <= cfg_data[23:0];
        REG_TEXEL_SCALE_2: texel_scale[2] <= cfg_data[23:0];
        REG_OUT_SCALE_0:   out_scale[0]   <= cfg_data;
        REG_OUT_SCALE_1:   out_scale[1]   <= cfg_data;
        REG_OUT_SCALE_2:   out_scale[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign idx_ext = {16'b0, idx_a};

  // Valid chain of the pipeline and the map write request.
  always_ff @(posedge clk) begin
    if (rst) begin
      {vld_a, vld_b, vld_c, vld_d, vld_e, vld_f, vld_g, vld_h} <= '0;
      result_valid <= 1'b0;
      wr_b.en      <= 1'b0;
    end else if (en) begin
      vld_a        <= sample_valid;
      vld_b        <= vld_a && (op_a == OP_SAMPLE);
      wr_b.en      <= vld_a && (op_a == OP_WRITE) && (32'(sel_a) < NUM_CASCADES)
                      && (32'(idx_a) < MAP_SIZE);
      wr_b.col     <= idx_ext[LOG2_DIM-1:0];
      wr_b.row     <= idx_ext[LOG2_DIM +: LOG2_DIM];
      wr_b.data    <= hv_a;
      vld_c        <= vld_b;
      vld_d        <= vld_c;
      vld_e        <= vld_d;
      vld_f        <= vld_e;
      vld_g        <= vld_f;
      vld_h        <= vld_g;
      result_valid <= vld_h;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (en) begin
      op_a   <= operation;
      wx_a   <= world_x;
      wz_a   <= world_z;
      mask_a <= cascade_mask;
      sel_a  <= cascade_select;
      idx_a  <= entry_index;
      hv_a   <= height_value;
    end
  end

  // Texel coordinates: scale into Q.32 texel space, Z negated.
  always_ff @(posedge clk) begin
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] pz;
    if (en) begin
      for (int c = 0; c < NUM_CASCADES; c++) begin
        px = PROD_W'(wx_a * $signed({1'b0, texel_scale[c]}));
        pz = -PROD_W'(wz_a * $signed({1'b0, texel_scale[c]}));
        rd_b[c].x <= px[32 +: LOG2_DIM];
        rd_b[c].z <= pz[32 +: LOG2_DIM];
        tx_b[c]   <= px[31:16];
        tz_b[c]   <= pz[31:16];
      end
      mask_b    <= mask_a;
      sel_b     <= sel_a;
    end
  end

  // Delay line for weights and mask alongside the map and blend stages.
  always_ff @(posedge clk) begin
    if (en) begin
      tx_c   <= tx_b;
      tz_c   <= tz_b;
      mask_c <= mask_b;
      mask_d <= mask_c;
      mask_e <= mask_d;
      mask_f <= mask_e;
    end
  end

  // One map and one blend unit per cascade.
  for (genvar c = 0; c < NUM_CASCADES; c++) begin : g_cascade
    map_write_t                 wr_c;
    logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;

    always_comb begin
      wr_c    = wr_b;
      wr_c.en = wr_b.en && (sel_b == 2'(c));
    end

    chs_height_map u_map (
      .clk (clk),
      .en  (en),
      .wr  (wr_c),
      .rd  (rd_b[c]),
      .h00 (h00),
      .h10 (h10),
      .h01 (h01),
      .h11 (h11)
    );

    chs_cascade_blend u_blend (
      .clk       (clk),
      .en        (en),
      .h00       (h00),
      .h10       (h10),
      .h01       (h01),
      .h11       (h11),
      .tx        (tx_c[c]),
      .tz        (tz_c[c]),
      .out_scale (out_scale[c]),
      .result    (res_f[c])
    );
  end

  // Sum of selected cascades, then wave scale.
  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] acc;
    if (en) begin
      acc = '0;
      for (int c = 0; c < NUM_CASCADES; c++) begin
        if (mask_f[c]) begin
          acc = acc + SUM_W'(res_f[c]);
        end
      end
      sum_g  <= acc;
      prod_h <= WAVE_P_W'(sum_g * $signed({1'b0, wave_scale}));
    end
  end

  // Round half up to Q16.16 and saturate.
  assign rounded = (prod_h + WAVE_P_W'(128)) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rounded > WAVE_P_W'(64'sd2147483647)) begin
        height <= 32'sh7FFFFFFF;
      end else if (rounded < -WAVE_P_W'(64'sd2147483648)) begin
        height <= 32'sh80000000;
      end else begin
        height <= rounded[31:0];
      end
    end
  end

  // A held pipeline keeps its sample valids.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld_b) && $stable(vld_h))
    else $error("pipeline valid moved while held");

  // A write and a sample never occupy the map stage together.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_b.en && vld_b))
    else $error("write and sample in map stage together");

  // A new result only follows a sample in the last stage.
  a_res: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(vld_h))
    else $error("result without a sample");

endmodule

/* design/chs_height_map.sv */
// ----------------------------------------------------------------------------
// chs_height_map
// One cascade's height map, split into four banks by column and row parity
// so that the four texels of a bilinear footprint are read together.
// ----------------------------------------------------------------------------
module chs_height_map
  import chs_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  map_write_t                 wr,
  input  map_read_t                  rd,
  output logic signed [HEIGHT_W-1:0] h00,
  output logic signed [HEIGHT_W-1:0] h10,
  output logic signed [HEIGHT_W-1:0] h01,
  output logic signed [HEIGHT_W-1:0] h11
);

  logic [HEIGHT_W-1:0] mem [4][BANK_DEPTH];
  logic [HEIGHT_W-1:0] rdata [4];
  logic [BANK_AW-1:0]  raddr [4];
  logic [BANK_AW-1:0]  waddr;
  logic [1:0]          wbank;
  texel_t              x1;
  texel_t              z1;
  logic                par_x;
  logic                par_z;

  // Neighbour texels wrap at the map edge.
  assign x1 = rd.x + texel_t'(1);
  assign z1 = rd.z + texel_t'(1);

  // Each bank serves whichever neighbour has its parity.
  always_comb begin
    texel_t xs;
    texel_t zs;
    for (int b = 0; b < 4; b++) begin
      xs = (rd.x[0] == b[0]) ? rd.x : x1;
      zs = (rd.z[0] == b[1]) ? rd.z : z1;
      raddr[b] = {zs[LOG2_DIM-1:1], xs[LOG2_DIM-1:1]};
    end
  end

  assign wbank = {wr.row[0], wr.col[0]};
  assign waddr = {wr.row[LOG2_DIM-1:1], wr.col[LOG2_DIM-1:1]};

  // Bank write and registered read; a write and a read in the same cycle
  // come from different requests in pipeline order.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        if (wr.en && (wbank == 2'(b))) begin
          mem[b][waddr] <= wr.data;
        end
        rdata[b] <= mem[b][raddr[b]];
      end
      par_x <= rd.x[0];
      par_z <= rd.z[0];
    end
  end

  // Route bank data back to footprint corners.
  assign h00 = $signed(rdata[{par_z, par_x}]);
  assign h10 = $signed(rdata[{par_z, ~par_x}]);
  assign h01 = $signed(rdata[{~par_z, par_x}]);
  assign h11 = $signed(rdata[{~par_z, ~par_x}]);

endmodule

/* design/chs_cascade_blend.sv */
// ----------------------------------------------------------------------------
// chs_cascade_blend
// Bilinear blend of four texels and scaling by the cascade output scale,
// over three registered stages.
// ----------------------------------------------------------------------------
module chs_cascade_blend
  import chs_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [HEIGHT_W-1:0] h00,
  input  logic signed [HEIGHT_W-1:0] h10,
  input  logic signed [HEIGHT_W-1:0] h01,
  input  logic signed [HEIGHT_W-1:0] h11,
  input  logic [15:0]                tx,
  input  logic [15:0]                tz,
  input  logic [31:0]                out_scale,
  output logic signed [RESULT_W-1:0] result
);

  logic signed [34:0]         a;
  logic signed [34:0]         b;
  logic [15:0]                tz_d;
  logic signed [BLEND_W-1:0]  blend;
  logic [16:0]                wx0;
  logic [16:0]                wz0;
  logic signed [53:0]         pre;
  logic signed [57:0]         scaled;

  assign wx0 = 17'h10000 - {1'b0, tx};
  assign wz0 = 17'h10000 - {1'b0, tz_d};

  // Blend along X for both rows.
  always_ff @(posedge clk) begin
    if (en) begin
      a    <= 35'(h00 * $signed({1'b0, wx0})) + 35'(h10 * $signed({2'b0, tx}));
      b    <= 35'(h01 * $signed({1'b0, wx0})) + 35'(h11 * $signed({2'b0, tx}));
      tz_d <= tz;
    end
  end

  // Blend along Z and round half up to Q.16.
  assign pre = 54'(a * $signed({1'b0, wz0})) + 54'(b * $signed({2'b0, tz_d}))
             + 54'(1 << 23);

  always_ff @(posedge clk) begin
    if (en) begin
      blend <= pre[48:24];
    end
  end

  // Output scale, rounded half up to Q16.16.
  assign scaled = 58'(blend * $signed({1'b0, out_scale})) + 58'(1 << 23);

  always_ff @(posedge clk) begin
    if (en) begin
      result <= scaled[56:24];
    end
  end

endmodule
